// ===== rtl/dbf_pkg.sv =====
// ============================================================================
// dbf_pkg: shared types and constants of the block edge deblocking filter
// Pixel line layout, stage payloads, register indexes and result path codes.
// ============================================================================
package dbf_pkg;

   localparam int PIX_W   = 8;
   localparam int SIDE_N  = 6;
   localparam int NUM_PIX = 2 * SIDE_N;
   localparam int LINE_W  = SIDE_N * PIX_W;
   localparam int QP_W    = 5;
   localparam int WIN_N   = 6;
   localparam int WIN_LEN = 7;
   localparam int WIN_W   = 11;
   localparam int ACT_W   = 12;
   localparam int MAG_W   = ACT_W - 1;
   localparam int PATH_W  = 2;
   localparam int CSR_IDX_W = 1;

   // pixel index 6+i holds pixel i, for i in -6..5; the edge lies between 5 and 6
   localparam int EDGE_LO  = 5;
   localparam int EDGE_HI  = 6;
   localparam int HARD_LO  = 3;

   localparam logic [PATH_W-1:0] PATH_NONE = 2'd0;
   localparam logic [PATH_W-1:0] PATH_HARD = 2'd1;
   localparam logic [PATH_W-1:0] PATH_SOFT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_HARD_THR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOFT_THR = 1'd1;

   localparam logic [PIX_W-1:0] HARD_THR_RST = 8'd4;
   localparam logic [PIX_W-1:0] SOFT_THR_RST = 8'd4;

   localparam logic [WIN_W-1:0] AVG_ROUND  = 11'd4;
   localparam logic [13:0]      CORR_ROUND = 14'd32;

   typedef logic [NUM_PIX-1:0][PIX_W-1:0] pix_arr_type;
   typedef logic [WIN_N-1:0][WIN_W-1:0]   win_arr_type;
   typedef logic [WIN_N-1:0][PIX_W-1:0]   avg_arr_type;

   typedef struct packed {
      logic [PIX_W-1:0] hard_thr;
      logic [PIX_W-1:0] soft_thr;
   } csr_type;

   typedef struct packed {
      logic [LINE_W-1:0] before_pixels;
      logic [LINE_W-1:0] after_pixels;
      logic [QP_W-1:0]   quant_param;
      logic              hard_mode;
   } req_type;

   typedef struct packed {
      pix_arr_type             pix;
      logic [QP_W-1:0]         quant_param;
      logic                    hard_mode;
      logic                    hard_ok;
      logic                    soft_thr_ok;
      logic signed [ACT_W-1:0] a0;
      logic signed [ACT_W-1:0] a1;
      logic signed [ACT_W-1:0] a2;
      win_arr_type             win;
   } front_type;

   typedef struct packed {
      pix_arr_type             pix;
      avg_arr_type             avg;
      logic [MAG_W-1:0]        amag;
      logic                    a0_pos;
      logic signed [PIX_W-1:0] half_step;
      logic [PATH_W-1:0]       path;
   } decide_type;

   typedef struct packed {
      logic [LINE_W-1:0] before_out;
      logic [LINE_W-1:0] after_out;
      logic [PATH_W-1:0] path_taken;
   } rsp_type;

endpackage

// ===== rtl/dbf_front.sv =====
// ============================================================================
// dbf_front: first pipeline stage
// Unpacks the line, forms the edge step tests, the weighted activities and
// the six seven-pixel window sums.
// ============================================================================
module dbf_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  dbf_pkg::req_type   in_data,
   input  dbf_pkg::csr_type   csr,
   output logic               out_valid,
   input  logic               out_ready,
   output dbf_pkg::front_type out_data
);
   import dbf_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   front_type data_ff;
   front_type data_in;

   logic signed [PIX_W:0] step;
   logic [PIX_W-1:0]      abs_step;
   logic [WIN_W-1:0]      acc;

   function automatic logic signed [ACT_W-1:0] weigh52(
      input logic [PIX_W-1:0] xp,
      input logic [PIX_W-1:0] xn,
      input logic [PIX_W-1:0] yp,
      input logic [PIX_W-1:0] yn
   );
      logic signed [ACT_W-1:0] x;
      logic signed [ACT_W-1:0] y;
      x = $signed({{(ACT_W-PIX_W){1'b0}}, xp}) - $signed({{(ACT_W-PIX_W){1'b0}}, xn});
      y = $signed({{(ACT_W-PIX_W){1'b0}}, yp}) - $signed({{(ACT_W-PIX_W){1'b0}}, yn});
      return (x <<< 2) + x + (y <<< 1);
   endfunction

   always_comb begin
      data_in = '0;
      acc     = '0;
      for (int k = 0; k < SIDE_N; k++) begin
         data_in.pix[EDGE_LO-k] = in_data.before_pixels[PIX_W*k +: PIX_W];
         data_in.pix[EDGE_HI+k] = in_data.after_pixels[PIX_W*k +: PIX_W];
      end
      step     = $signed({1'b0, data_in.pix[EDGE_HI]}) - $signed({1'b0, data_in.pix[EDGE_LO]});
      abs_step = step[PIX_W] ? PIX_W'(-step) : step[PIX_W-1:0];

      data_in.quant_param = in_data.quant_param;
      data_in.hard_mode   = in_data.hard_mode;
      data_in.hard_ok     = (abs_step > csr.hard_thr) &&
                            (abs_step < {{(PIX_W-QP_W){1'b0}}, in_data.quant_param});
      data_in.soft_thr_ok = abs_step > csr.soft_thr;
      data_in.a0 = weigh52(data_in.pix[6], data_in.pix[5], data_in.pix[4], data_in.pix[7]);
      data_in.a1 = weigh52(data_in.pix[4], data_in.pix[3], data_in.pix[2], data_in.pix[5]);
      data_in.a2 = weigh52(data_in.pix[8], data_in.pix[7], data_in.pix[6], data_in.pix[9]);

      for (int j = 0; j < WIN_N; j++) begin
         acc = '0;
         for (int i = 0; i < WIN_LEN; i++) begin
            acc = acc + {{(WIN_W-PIX_W){1'b0}}, data_in.pix[j+i]};
         end
         data_in.win[j] = acc;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/dbf_decide.sv =====
// ============================================================================
// dbf_decide: second pipeline stage
// Chooses the filter path, forms the hard filter averages and the soft
// filter activity difference and half step.
// ============================================================================
module dbf_decide (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  dbf_pkg::front_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output dbf_pkg::decide_type out_data
);
   import dbf_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   decide_type data_ff;
   decide_type data_in;

   logic [MAG_W-1:0]        ab0;
   logic [MAG_W-1:0]        ab1;
   logic [MAG_W-1:0]        ab2;
   logic [MAG_W-1:0]        ab_min;
   logic signed [ACT_W-1:0] act_diff;
   logic                    act_ok;
   logic                    act_pos;
   logic signed [PIX_W:0]   neg_step;
   logic [WIN_W-1:0]        avg_sum;

   function automatic logic [MAG_W-1:0] mag(input logic signed [ACT_W-1:0] x);
      return x[ACT_W-1] ? MAG_W'(-x) : x[MAG_W-1:0];
   endfunction

   always_comb begin
      data_in = '0;
      avg_sum = '0;
      ab0     = mag(in_data.a0);
      ab1     = mag(in_data.a1);
      ab2     = mag(in_data.a2);
      ab_min  = (ab1 < ab2) ? ab1 : ab2;
      act_diff = $signed({1'b0, ab0}) - $signed({1'b0, ab_min});
      act_pos  = !act_diff[ACT_W-1] && (act_diff != '0);
      act_ok   = ab0 < {{(MAG_W-QP_W-3){1'b0}}, in_data.quant_param, 3'b000};
      neg_step = $signed({1'b0, in_data.pix[EDGE_LO]}) - $signed({1'b0, in_data.pix[EDGE_HI]});

      for (int j = 0; j < WIN_N; j++) begin
         avg_sum = in_data.win[j] + {{(WIN_W-PIX_W){1'b0}}, in_data.pix[HARD_LO+j]} + AVG_ROUND;
         data_in.avg[j] = avg_sum[WIN_W-1:3];
      end

      data_in.pix       = in_data.pix;
      data_in.amag      = act_diff[MAG_W-1:0];
      data_in.a0_pos    = !in_data.a0[ACT_W-1] && (in_data.a0 != '0);
      data_in.half_step = neg_step[PIX_W:1];

      if (in_data.hard_mode) begin
         data_in.path = in_data.hard_ok ? PATH_HARD : PATH_NONE;
      end else begin
         data_in.path = (in_data.soft_thr_ok && act_ok && act_pos) ? PATH_SOFT : PATH_NONE;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/dbf_apply.sv =====
// ============================================================================
// dbf_apply: third pipeline stage and output register
// Forms the clamped soft correction, writes the filtered pixels and packs
// the result item.
// ============================================================================
module dbf_apply (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  dbf_pkg::decide_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output dbf_pkg::rsp_type    out_data
);
   import dbf_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;
   rsp_type data_in;
   logic    load;

   logic [13:0]           corr_prod;
   logic [PIX_W-1:0]      corr_mag;
   logic signed [9:0]     corr_raw;
   logic signed [9:0]     half10;
   logic signed [9:0]     corr;
   pix_arr_type           opix;
   logic [LINE_W-1:0]     orig_before;
   logic [LINE_W-1:0]     orig_after;

   always_comb begin
      corr_prod = {1'b0, in_data.amag, 2'b00} + {3'b000, in_data.amag} + CORR_ROUND;
      corr_mag  = corr_prod[13:6];
      corr_raw  = in_data.a0_pos ? -$signed({2'b00, corr_mag}) : $signed({2'b00, corr_mag});
      half10    = $signed({{2{in_data.half_step[PIX_W-1]}}, in_data.half_step});

      if (!half10[9]) begin
         if (half10 >= corr_raw) begin
            corr = (corr_raw > 10'sd0) ? corr_raw : 10'sd0;
         end else begin
            corr = half10;
         end
      end else begin
         if (corr_raw > 10'sd0) begin
            corr = 10'sd0;
         end else begin
            corr = (corr_raw > half10) ? corr_raw : half10;
         end
      end

      opix = in_data.pix;
      case (in_data.path)
         PATH_HARD: begin
            for (int j = 0; j < WIN_N; j++) begin
               opix[HARD_LO+j] = in_data.avg[j];
            end
         end
         PATH_SOFT: begin
            opix[EDGE_LO] = in_data.pix[EDGE_LO] - corr[PIX_W-1:0];
            opix[EDGE_HI] = in_data.pix[EDGE_HI] + corr[PIX_W-1:0];
         end
         default: begin
         end
      endcase

      data_in = '0;
      orig_before = '0;
      orig_after  = '0;
      for (int k = 0; k < SIDE_N; k++) begin
         data_in.before_out[PIX_W*k +: PIX_W] = opix[EDGE_LO-k];
         data_in.after_out[PIX_W*k +: PIX_W]  = opix[EDGE_HI+k];
         orig_before[PIX_W*k +: PIX_W]        = in_data.pix[EDGE_LO-k];
         orig_after[PIX_W*k +: PIX_W]         = in_data.pix[EDGE_HI+k];
      end
      data_in.path_taken = in_data.path;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign load      = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   a_none_passes: assert property (@(posedge clock) disable iff (reset)
      (load && in_data.path == PATH_NONE) |=>
         (data_ff.before_out == $past(orig_before) && data_ff.after_out == $past(orig_after)))
      else $error("unfiltered item altered");

   a_soft_edge_only: assert property (@(posedge clock) disable iff (reset)
      (load && in_data.path == PATH_SOFT) |=>
         (data_ff.before_out[LINE_W-1:PIX_W] == $past(orig_before[LINE_W-1:PIX_W]) &&
          data_ff.after_out[LINE_W-1:PIX_W] == $past(orig_after[LINE_W-1:PIX_W])))
      else $error("soft filter touched pixels away from the edge");

   a_hard_inner_only: assert property (@(posedge clock) disable iff (reset)
      (load && in_data.path == PATH_HARD) |=>
         (data_ff.before_out[LINE_W-1:3*PIX_W] == $past(orig_before[LINE_W-1:3*PIX_W]) &&
          data_ff.after_out[LINE_W-1:3*PIX_W] == $past(orig_after[LINE_W-1:3*PIX_W])))
      else $error("hard filter touched outer pixels");

   a_reset_empties: assert property (@(posedge clock) reset |=> !valid_ff)
      else $error("output register holds an item after reset");

endmodule

// ===== rtl/block_edge_deblock_filter_top.sv =====
// ============================================================================
// block_edge_deblock_filter_top: deblocking filter for one pixel line
// Filters a twelve pixel line across a block edge, hard or soft.
// ============================================================================
// Use: present a line on the req_ channel (six pixels before the edge, six
// from the edge on, the quantiser and the hard mode flag); the filtered line
// and the path taken leave on the rsp_ channel, one result item per item, in
// order. Both channels use valid/ready.
// The result passes three register stages (step tests and window sums, path
// choice and averages, correction and output register) before rsp_valid.
// Throughput is one item per cycle while the receiver does not stall.
// The thresholds are written through csr_write_en/csr_index/csr_wdata; the user
// must do so while no item is in flight (not enforced); reset sets both to 4.
// Reset empties all stages. When the receiver stalls, the output register
// holds its item and earlier stages keep filling until each holds one item;
// req_ready then drops, and nothing is lost or repeated.
// ============================================================================
module block_edge_deblock_filter_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [dbf_pkg::LINE_W-1:0]      req_before_pixels,
   input  logic [dbf_pkg::LINE_W-1:0]      req_after_pixels,
   input  logic [dbf_pkg::QP_W-1:0]        req_quant_param,
   input  logic                            req_hard_mode,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [dbf_pkg::LINE_W-1:0]      rsp_before_out,
   output logic [dbf_pkg::LINE_W-1:0]      rsp_after_out,
   output logic [dbf_pkg::PATH_W-1:0]      rsp_path_taken,
   input  logic                            csr_write_en,
   input  logic [dbf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dbf_pkg::PIX_W-1:0]       csr_wdata
);
   import dbf_pkg::*;

   csr_type    csr_ff;
   csr_type    csr_in;
   req_type    req_data;
   front_type  front_data;
   decide_type decide_data;
   rsp_type    rsp_data;
   logic       front_valid;
   logic       front_ready;
   logic       decide_valid;
   logic       decide_ready;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_HARD_THR: csr_in.hard_thr = csr_wdata;
            CSR_SOFT_THR: csr_in.soft_thr = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.hard_thr <= HARD_THR_RST;
         csr_ff.soft_thr <= SOFT_THR_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign req_data.before_pixels = req_before_pixels;
   assign req_data.after_pixels  = req_after_pixels;
   assign req_data.quant_param   = req_quant_param;
   assign req_data.hard_mode     = req_hard_mode;

   dbf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .csr       (csr_ff),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   dbf_decide u_decide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (decide_valid),
      .out_ready (decide_ready),
      .out_data  (decide_data)
   );

   dbf_apply u_apply (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (decide_valid),
      .in_ready  (decide_ready),
      .in_data   (decide_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_before_out = rsp_data.before_out;
   assign rsp_after_out  = rsp_data.after_out;
   assign rsp_path_taken = rsp_data.path_taken;

endmodule

// ===== bench/tb_block_edge_deblock_filter_top.sv =====
// ============================================================================
// tb_block_edge_deblock_filter_top: self-checking bench for the deblock filter
// Drives pixel lines through the req_ channel under random gaps and stalls,
// predicts each filtered line and checks every rsp_ item in order.
// Thresholds are rewritten between phases, extremes included.
// ============================================================================
module tb_block_edge_deblock_filter_top;
   import dbf_pkg::*;

   class line_scoreboard;
      logic [PIX_W-1:0] hard_thr;
      logic [PIX_W-1:0] soft_thr;
      rsp_type          pending_lines[$];
      int               fault_count;

      function new();
         hard_thr    = HARD_THR_RST;
         soft_thr    = SOFT_THR_RST;
         fault_count = 0;
      endfunction

      function void set_thresholds(logic [PIX_W-1:0] hard_val, logic [PIX_W-1:0] soft_val);
         hard_thr = hard_val;
         soft_thr = soft_val;
      endfunction

      function int mag(int x);
         return (x < 0) ? -x : x;
      endfunction

      function rsp_type filter_line(req_type line);
         int      p[12];
         int      o[12];
         int      qp, d, s, a0, a1, a2, a, c, h;
         rsp_type res;
         qp = line.quant_param;
         for (int i = 0; i < SIDE_N; i++) begin
            p[5 - i] = line.before_pixels[8*i +: 8];
            p[6 + i] = line.after_pixels[8*i +: 8];
         end
         for (int i = 0; i < NUM_PIX; i++) o[i] = p[i];
         d = p[6] - p[5];
         res.path_taken = PATH_NONE;
         if (line.hard_mode) begin
            if (mag(d) > int'(hard_thr) && mag(d) < qp) begin
               s = 0;
               for (int i = 0; i <= 6; i++) s += p[i];
               o[3] = (s + p[3] + 4) >> 3;
               for (int k = 0; k < 5; k++) begin
                  s = s - p[k] + p[7 + k];
                  o[4 + k] = (s + p[4 + k] + 4) >> 3;
               end
               res.path_taken = PATH_HARD;
            end
         end else if (mag(d) > int'(soft_thr)) begin
            a0 = 5 * d + 2 * (p[4] - p[7]);
            if (mag(a0) < qp * 8) begin
               a1 = 5 * (p[4] - p[3]) + 2 * (p[2] - p[5]);
               a2 = 5 * (p[8] - p[7]) + 2 * (p[6] - p[9]);
               a  = mag(a0) - ((mag(a1) < mag(a2)) ? mag(a1) : mag(a2));
               if (a > 0) begin
                  c = (5 * a + 32) >> 6;
                  if (a0 > 0) c = -c;
                  h = (p[5] - p[6]) >>> 1;
                  if (h >= 0) begin
                     if (h >= c) h = (c > 0) ? c : 0;
                  end else begin
                     if (c > 0) h = 0;
                     else h = (c > h) ? c : h;
                  end
                  o[5] = (p[5] - h) & 255;
                  o[6] = (p[6] + h) & 255;
                  res.path_taken = PATH_SOFT;
               end
            end
         end
         for (int i = 0; i < SIDE_N; i++) begin
            res.before_out[8*i +: 8] = 8'(o[5 - i]);
            res.after_out[8*i +: 8]  = 8'(o[6 + i]);
         end
         return res;
      endfunction

      function void note_line(req_type line);
         pending_lines.push_back(filter_line(line));
      endfunction

      task report(string msg);
         $display("%0t  mismatch: %s", $time, msg);
         fault_count++;
      endtask

      task check_line(rsp_type got);
         rsp_type want;
         if (pending_lines.size() == 0) begin
            report("result item with no line pending");
         end else begin
            want = pending_lines.pop_front();
            if (got.before_out !== want.before_out)
               report($sformatf("before_out %h, want %h", got.before_out, want.before_out));
            if (got.after_out !== want.after_out)
               report($sformatf("after_out %h, want %h", got.after_out, want.after_out));
            if (got.path_taken !== want.path_taken)
               report($sformatf("path_taken %0d, want %0d", got.path_taken, want.path_taken));
         end
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [LINE_W-1:0]    req_before_pixels = '0;
   logic [LINE_W-1:0]    req_after_pixels = '0;
   logic [QP_W-1:0]      req_quant_param = '0;
   logic                 req_hard_mode = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [LINE_W-1:0]    rsp_before_out;
   logic [LINE_W-1:0]    rsp_after_out;
   logic [PATH_W-1:0]    rsp_path_taken;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_HARD_THR;
   logic [PIX_W-1:0]     csr_wdata = '0;

   int unsigned    send_gap_pct = 6;
   int unsigned    recv_stall_pct = 84;
   line_scoreboard sb = new();

   block_edge_deblock_filter_top dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.note_line('{req_before_pixels, req_after_pixels, req_quant_param, req_hard_mode});
      if (!reset && rsp_valid && rsp_ready)
         sb.check_line('{rsp_before_out, rsp_after_out, rsp_path_taken});
   end

   function automatic int clamp_pixel(int v);
      return (v < 0) ? 0 : (v > 255) ? 255 : v;
   endfunction

   // mostly smooth lines with a step at the edge, some pure noise
   function automatic req_type random_line();
      req_type line;
      int      base, step, spread;
      if ($urandom_range(99) < 20) begin
         line.before_pixels[47:32] = 16'($urandom);
         line.before_pixels[31:0]  = $urandom;
         line.after_pixels[47:32]  = 16'($urandom);
         line.after_pixels[31:0]   = $urandom;
         line.quant_param          = 5'($urandom);
      end else begin
         base   = int'($urandom_range(255));
         step   = int'($urandom_range(80)) - 40;
         spread = int'($urandom_range(8));
         for (int i = 0; i < SIDE_N; i++) begin
            line.before_pixels[8*i +: 8] =
               8'(clamp_pixel(base + int'($urandom_range(2 * spread)) - spread));
            line.after_pixels[8*i +: 8] =
               8'(clamp_pixel(base + step + int'($urandom_range(2 * spread)) - spread));
         end
         line.quant_param = ($urandom_range(19) == 0) ? 5'd0 : 5'($urandom_range(31, 1));
      end
      line.hard_mode = 1'($urandom);
      return line;
   endfunction

   task automatic send_line(req_type line);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_before_pixels <= line.before_pixels;
      req_after_pixels  <= line.after_pixels;
      req_quant_param   <= line.quant_param;
      req_hard_mode     <= line.hard_mode;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_random(int count);
      for (int n = 0; n < count; n++) send_line(random_line());
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_lines.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_thresholds(logic [PIX_W-1:0] hard_val, logic [PIX_W-1:0] soft_val);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_HARD_THR;
      csr_wdata    <= hard_val;
      @(posedge clock);
      csr_index    <= CSR_SOFT_THR;
      csr_wdata    <= soft_val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.set_thresholds(hard_val, soft_val);
      @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero quantiser, saturated lines
      send_line('{48'h000000000000, 48'h000000000000, 5'd0, 1'b1});
      send_line('{48'h000000000000, 48'h000000000000, 5'd0, 1'b0});
      send_line('{48'hFFFFFFFFFFFF, 48'hFFFFFFFFFFFF, 5'd31, 1'b1});
      send_line('{48'hFFFFFFFFFFFF, 48'hFFFFFFFFFFFF, 5'd31, 1'b0});
      // hard filter: up and down steps, threshold and quantiser bounds
      send_line('{48'h646464646464, 48'h6E6E6E6E6E6E, 5'd31, 1'b1});
      send_line('{48'hC8C8C8C8C8C8, 48'hBEBEBEBEBEBE, 5'd31, 1'b1});
      send_line('{48'h646464646464, 48'h686868686868, 5'd31, 1'b1});
      send_line('{48'h646464646464, 48'h696969696969, 5'd6, 1'b1});
      send_line('{48'h646464646464, 48'h6A6A6A6A6A6A, 5'd6, 1'b1});
      send_line('{48'h646464646464, 48'h6E6E6E6E6E6E, 5'd0, 1'b1});
      // soft filter: both signs, zero correction, failed tests; then mixed lines in both modes
      send_line('{48'h646464646464, 48'h6E6E6E6E6E6E, 5'd31, 1'b0});
      send_line('{48'h6E6E6E6E6E6E, 48'h646464646464, 5'd31, 1'b0});
      send_line('{48'h646466606464, 48'h6464696E6469, 5'd31, 1'b0});
      send_line('{48'h646464646464, 48'h686868686868, 5'd31, 1'b0});
      send_line('{48'h646464646464, 48'h6E6E6E6E6E6E, 5'd1, 1'b0});
      send_line('{48'h646464646464, 48'h6E6E6E6E6E6E, 5'd0, 1'b0});
      send_line('{48'h000000000000, 48'hFFFFFFFFFFFF, 5'd31, 1'b1});
      send_line('{48'h000000000000, 48'hFFFFFFFFFFFF, 5'd31, 1'b0});
      send_line('{48'h00FF00FF00FF, 48'hFF00FF00FF00, 5'd31, 1'b0});
      send_line('{48'hFFFFFFFFFFFF, 48'h000000000000, 5'd31, 1'b0});
      send_line('{48'h3C32281E140A, 48'h0A141E28323C, 5'd17, 1'b0});
      send_line('{48'h5A5C5E606264, 48'h70727476787A, 5'd20, 1'b1});

      send_random(140);
      drain();
      write_thresholds(8'd0, 8'd0);
      send_random(140);

      drain();
      send_gap_pct   = 84;
      recv_stall_pct = 6;
      write_thresholds(8'd255, 8'd255);
      send_random(140);
      drain();
      write_thresholds(8'($urandom_range(30)), 8'($urandom_range(40)));
      send_random(140);

      drain();
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      write_thresholds(8'd0, 8'd255);
      send_random(140);
      drain();
      write_thresholds(8'd31, 8'd2);
      send_random(140);

      drain();
      if (sb.fault_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== block_edge_deblock_filter_top.f =====
rtl/dbf_pkg.sv
rtl/dbf_front.sv
rtl/dbf_decide.sv
rtl/dbf_apply.sv
rtl/block_edge_deblock_filter_top.sv
bench/tb_block_edge_deblock_filter_top.sv
